>>> src/frm_pkg.sv
// shared types and constants for the firewall rule matcher
`default_nettype none

package frm_pkg;

    localparam int MAX_RULES_DEF = 64;

    localparam int KIND_W = 2;
    localparam int PORT_W = 16;
    localparam int ADDR_W = 32;

    localparam logic [KIND_W-1:0] KIND_BIND_ALLOW    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CONNECT_ALLOW = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CONNECT_DENY  = 2'd2;

    typedef enum logic [1:0] {
        FUNC_INSERT  = 2'd0,
        FUNC_BIND    = 2'd1,
        FUNC_CONNECT = 2'd2,
        FUNC_CLEAR   = 2'd3
    } t_func;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] mask;
    } t_rule;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

>>> src/frm_rule_ram.sv
// rule table: one write port, one read port with registered read data
`default_nettype none

module frm_rule_ram #(
    parameter int DEPTH = frm_pkg::MAX_RULES_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire frm_pkg::t_mem_ctl i_ctl,
    input  wire logic [IDX_W-1:0] i_wr_addr,
    input  wire frm_pkg::t_rule   i_wr_data,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    output frm_pkg::t_rule        o_rd_data
);
    import frm_pkg::*;

    t_rule r_mem [DEPTH];
    t_rule r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> src/frm_ctrl.sv
// command sequencer: rule count, table scan and verdict
`default_nettype none

module frm_ctrl #(
    parameter int MAX_RULES = frm_pkg::MAX_RULES_DEF,
    parameter int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1,
    parameter int CNT_W     = $clog2(MAX_RULES + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire frm_pkg::t_func         i_func,
    input  wire logic [frm_pkg::KIND_W-1:0] i_rule_kind,
    input  wire logic [frm_pkg::PORT_W-1:0] i_port,
    input  wire logic [frm_pkg::ADDR_W-1:0] i_ip_addr,
    input  wire logic [frm_pkg::ADDR_W-1:0] i_net_mask,
    output logic                        o_busy,
    output logic                        o_strobe,
    output logic                        o_allowed,
    output logic                        o_status,
    output frm_pkg::t_mem_ctl           o_mem_ctl,
    output logic [IDX_W-1:0]            o_wr_addr,
    output frm_pkg::t_rule              o_wr_data,
    output logic [IDX_W-1:0]            o_rd_addr,
    input  wire frm_pkg::t_rule         i_rd_data
);
    import frm_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_addr, n_addr;
    logic               r_rd_more, n_rd_more;
    logic               r_pend, n_pend;
    logic               r_pend_last, n_pend_last;
    logic               r_is_bind, n_is_bind;
    logic [PORT_W-1:0]  r_port, n_port;
    logic [ADDR_W-1:0]  r_ip, n_ip;
    logic               r_strobe, n_strobe;
    logic               r_allowed, n_allowed;
    logic               r_status, n_status;

    logic               accept;
    logic               tbl_full;
    logic               port_hit;
    logic               addr_hit;
    logic               rule_hit;
    logic               verdict;
    logic [CNT_W-1:0]   last_idx;

    assign accept   = i_start && (r_state == ST_IDLE);
    assign tbl_full = (r_count == CNT_W'(MAX_RULES));
    assign last_idx = r_count - CNT_W'(1);

    // match of the rule returned by the memory against the latched check
    assign port_hit = (i_rd_data.port == '0) || (i_rd_data.port == r_port);
    assign addr_hit = ((r_ip ^ i_rd_data.addr) & i_rd_data.mask) == '0;

    always_comb begin
        if (r_is_bind) begin
            rule_hit = (i_rd_data.kind == KIND_BIND_ALLOW) && port_hit;
            verdict  = 1'b1;
        end else begin
            rule_hit = ((i_rd_data.kind == KIND_CONNECT_ALLOW) ||
                        (i_rd_data.kind == KIND_CONNECT_DENY)) && addr_hit && port_hit;
            verdict  = (i_rd_data.kind == KIND_CONNECT_ALLOW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_rd_more <= 1'b0;
            r_pend    <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_more <= n_rd_more;
            r_pend    <= n_pend;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_pend_last <= n_pend_last;
        r_is_bind   <= n_is_bind;
        r_port      <= n_port;
        r_ip        <= n_ip;
        r_allowed   <= n_allowed;
        r_status    <= n_status;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_rd_more   = r_rd_more;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        n_is_bind   = r_is_bind;
        n_port      = r_port;
        n_ip        = r_ip;
        n_strobe    = 1'b0;
        n_allowed   = r_allowed;
        n_status    = r_status;
        o_mem_ctl   = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_port    = i_port;
                    n_ip      = i_ip_addr;
                    n_is_bind = (i_func == FUNC_BIND);
                    n_allowed = 1'b0;
                    n_status  = 1'b0;
                    case (i_func)
                        FUNC_INSERT: begin
                            n_strobe = 1'b1;
                            if (tbl_full) begin
                                n_status = 1'b1;
                            end else begin
                                o_mem_ctl.wr_en = 1'b1;
                                n_count         = r_count + CNT_W'(1);
                            end
                        end
                        FUNC_BIND, FUNC_CONNECT: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                            end else begin
                                // scan newest to oldest
                                n_state   = ST_SCAN;
                                n_addr    = last_idx[IDX_W-1:0];
                                n_rd_more = 1'b1;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_strobe = 1'b1;
                            n_count  = '0;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                o_mem_ctl.rd_en = r_rd_more;
                if (r_rd_more) begin
                    n_pend      = 1'b1;
                    n_pend_last = (r_addr == '0);
                    if (r_addr == '0) begin
                        n_rd_more = 1'b0;
                    end else begin
                        n_addr = r_addr - IDX_W'(1);
                    end
                end
                if (r_pend && (rule_hit || r_pend_last)) begin
                    n_state   = ST_IDLE;
                    n_strobe  = 1'b1;
                    n_allowed = rule_hit && verdict;
                    n_rd_more = 1'b0;
                    n_pend    = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // the write lands at the end of the accepting cycle, before any later read
    assign o_wr_addr      = r_count[IDX_W-1:0];
    assign o_wr_data.kind = i_rule_kind;
    assign o_wr_data.port = i_port;
    assign o_wr_data.addr = i_ip_addr;
    assign o_wr_data.mask = i_net_mask;
    assign o_rd_addr      = r_addr;

    assign o_busy    = (r_state != ST_IDLE);
    assign o_strobe  = r_strobe;
    assign o_allowed = r_allowed;
    assign o_status  = r_status;

endmodule

`default_nettype wire

>>> src/firewall_rule_matcher_unit.sv
// top level of the firewall rule matcher
`default_nettype none

// First-match rule lookup over a table of up to MAX_RULES rules held in one
// synchronous memory. A transaction is taken when start is high and busy is
// low; its result appears on o_allowed/o_status for one cycle with o_strobe,
// and the receiver cannot stall it. Insert and clear never raise busy: the
// result follows in the next cycle. A bind or connect check reads the stored
// rules one per cycle, newest first, through the single memory read port, and
// stops at the first hit; an empty table answers without raising busy, and
// otherwise at most rule_count rules are read. A new rule is written in the
// cycle its insert is taken, so a check that follows at once already sees it.
module firewall_rule_matcher_unit #(
    parameter int MAX_RULES = frm_pkg::MAX_RULES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_func,
    input  wire logic [frm_pkg::KIND_W-1:0]  i_rule_kind,
    input  wire logic [frm_pkg::PORT_W-1:0]  i_port,
    input  wire logic [frm_pkg::ADDR_W-1:0]  i_ip_addr,
    input  wire logic [frm_pkg::ADDR_W-1:0]  i_net_mask,
    output logic                             o_strobe,
    output logic                             o_allowed,
    output logic                             o_status
);
    import frm_pkg::*;

    localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W = $clog2(MAX_RULES + 1);

    t_mem_ctl          mem_ctl;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  rd_addr;
    t_rule             wr_data;
    t_rule             rd_data;

    frm_ctrl #(
        .MAX_RULES (MAX_RULES),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_func      (t_func'(i_func)),
        .i_rule_kind (i_rule_kind),
        .i_port      (i_port),
        .i_ip_addr   (i_ip_addr),
        .i_net_mask  (i_net_mask),
        .o_busy      (busy),
        .o_strobe    (o_strobe),
        .o_allowed   (o_allowed),
        .o_status    (o_status),
        .o_mem_ctl   (mem_ctl),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    frm_rule_ram #(
        .DEPTH (MAX_RULES),
        .IDX_W (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // a result always retires the transaction
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while still busy");

    // insert and clear answer in the next cycle without going busy
    a_quick_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == FUNC_INSERT || i_func == FUNC_CLEAR))
        |=> (o_strobe && !busy))
        else $error("insert or clear did not answer in one cycle");

    // memory is never written and read in the same cycle
    a_mem_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("rule memory written during a scan");

    // busy only rises on a taken check
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a transaction");

endmodule

`default_nettype wire

>>> bench/firewall_rule_matcher_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the firewall rule matcher unit
module firewall_rule_matcher_unit_tb;
    import frm_pkg::*;

    localparam int TABLE_DEPTH  = MAX_RULES_DEF;
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
    localparam int DRAIN_LIMIT  = 1000;

    // a kind outside the defined set: stored but never matches
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

    typedef struct {
        logic allowed;
        logic status;
    } t_verdict;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    logic [1:0]        i_func      = FUNC_INSERT;
    logic [KIND_W-1:0] i_rule_kind = '0;
    logic [PORT_W-1:0] i_port      = '0;
    logic [ADDR_W-1:0] i_ip_addr   = '0;
    logic [ADDR_W-1:0] i_net_mask  = '0;
    logic              o_strobe;
    logic              o_allowed;
    logic              o_status;

    // shadow copy of the rule table
    logic [KIND_W-1:0] tbl_kind [TABLE_DEPTH];
    logic [PORT_W-1:0] tbl_port [TABLE_DEPTH];
    logic [ADDR_W-1:0] tbl_addr [TABLE_DEPTH];
    logic [ADDR_W-1:0] tbl_mask [TABLE_DEPTH];
    int                tbl_count = 0;

    t_verdict pending_verdicts[$];
    int       error_count  = 0;
    int       results_seen = 0;
    int       random_sent  = 0;
    bit       no_idle      = 1'b0;

    always #2 i_clk = ~i_clk;

    firewall_rule_matcher_unit #(
        .MAX_RULES(TABLE_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_func     (i_func),
        .i_rule_kind(i_rule_kind),
        .i_port     (i_port),
        .i_ip_addr  (i_ip_addr),
        .i_net_mask (i_net_mask),
        .o_strobe   (o_strobe),
        .o_allowed  (o_allowed),
        .o_status   (o_status)
    );

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t ns, result %0d: %s", $realtime, results_seen, msg);
        error_count++;
    endtask

    // applies one transaction to the shadow table and returns its verdict
    function automatic t_verdict rule_verdict(t_func func, logic [KIND_W-1:0] kind,
                                              logic [PORT_W-1:0] port,
                                              logic [ADDR_W-1:0] ip,
                                              logic [ADDR_W-1:0] mask);
        t_verdict v;
        bit       hit;
        v.allowed = 1'b0;
        v.status  = 1'b0;
        hit       = 1'b0;
        case (func)
            FUNC_INSERT: begin
                if (tbl_count >= TABLE_DEPTH) begin
                    v.status = 1'b1;
                end else begin
                    tbl_kind[tbl_count] = kind;
                    tbl_port[tbl_count] = port;
                    tbl_addr[tbl_count] = ip;
                    tbl_mask[tbl_count] = mask;
                    tbl_count++;
                end
            end
            FUNC_BIND: begin
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_kind[i] == KIND_BIND_ALLOW &&
                        (tbl_port[i] == '0 || tbl_port[i] == port))
                        v.allowed = 1'b1;
                end
            end
            FUNC_CONNECT: begin
                // newest first, first hit decides
                for (int i = tbl_count - 1; i >= 0 && !hit; i--) begin
                    if ((tbl_kind[i] == KIND_CONNECT_ALLOW || tbl_kind[i] == KIND_CONNECT_DENY) &&
                        (ip & tbl_mask[i]) == (tbl_addr[i] & tbl_mask[i]) &&
                        (tbl_port[i] == '0 || tbl_port[i] == port)) begin
                        hit       = 1'b1;
                        v.allowed = (tbl_kind[i] == KIND_CONNECT_ALLOW);
                    end
                end
            end
            default: tbl_count = 0;
        endcase
        return v;
    endfunction

    // called at a rising edge; returns at a rising edge
    task automatic send_item(t_func func, logic [KIND_W-1:0] kind, logic [PORT_W-1:0] port,
                             logic [ADDR_W-1:0] ip, logic [ADDR_W-1:0] mask);
        int gap;
        start       <= 1'b1;
        i_func      <= func;
        i_rule_kind <= kind;
        i_port      <= port;
        i_ip_addr   <= ip;
        i_net_mask  <= mask;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_verdicts.push_back(rule_verdict(func, kind, port, ip, mask));
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n && o_strobe === 1'b1) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
            end else begin
                want = pending_verdicts.pop_front();
                if (o_allowed !== want.allowed)
                    report_mismatch($sformatf("allowed %b, expected %b", o_allowed, want.allowed));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %b, expected %b", o_status, want.status));
            end
        end
    end

    function automatic logic [ADDR_W-1:0] pick_mask();
        int plen;
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        plen = $urandom_range(0, 32);
        return (plen == 0) ? '0 : ~32'h0 << (32 - plen);
    endfunction

    // addresses cluster around a few networks so that rules actually hit
    function automatic logic [ADDR_W-1:0] pick_addr();
        logic [ADDR_W-1:0] base;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       base = 32'h0A00_0000;
            1:       base = 32'hC0A8_0100;
            2:       base = 32'hAC10_0000;
            default: base = 32'hFFFF_FF00;
        endcase
        return base ^ ($urandom & ((32'h1 << $urandom_range(0, 16)) - 1));
    endfunction

    function automatic logic [PORT_W-1:0] pick_port();
        case ($urandom_range(0, 7))
            0, 1:    return '0;
            2:       return 16'd22;
            3:       return 16'd80;
            4:       return 16'd443;
            5:       return 16'hFFFF;
            default: return PORT_W'($urandom);
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        case ($urandom_range(0, 9))
            0, 1, 2: return KIND_BIND_ALLOW;
            3, 4, 5: return KIND_CONNECT_ALLOW;
            6, 7, 8: return KIND_CONNECT_DENY;
            default: return KIND_UNKNOWN;
        endcase
    endfunction

    task automatic send_random(t_func func);
        send_item(func, pick_kind(), pick_port(), pick_addr(),
                  (func == FUNC_INSERT) ? pick_mask() : $urandom);
        random_sent++;
    endtask

    task automatic test_empty_table();
        send_item(FUNC_CLEAR, KIND_UNKNOWN, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(FUNC_BIND, KIND_BIND_ALLOW, 16'd80, $urandom, $urandom);
        send_item(FUNC_CONNECT, KIND_CONNECT_ALLOW, '0, '0, '0);
    endtask

    task automatic test_bind_rules();
        send_item(FUNC_INSERT, KIND_BIND_ALLOW, 16'd80, $urandom, $urandom);
        send_item(FUNC_BIND, KIND_UNKNOWN, 16'd80, $urandom, $urandom);
        send_item(FUNC_BIND, KIND_BIND_ALLOW, 16'd81, $urandom, $urandom);
        send_item(FUNC_INSERT, KIND_UNKNOWN, '0, '0, '0);
        send_item(FUNC_BIND, KIND_BIND_ALLOW, 16'd81, $urandom, $urandom);
        send_item(FUNC_CONNECT, KIND_BIND_ALLOW, 16'd81, $urandom, $urandom);
        send_item(FUNC_INSERT, KIND_BIND_ALLOW, '0, $urandom, $urandom);
        send_item(FUNC_BIND, KIND_BIND_ALLOW, 16'hFFFF, $urandom, $urandom);
    endtask

    task automatic test_connect_priority();
        send_item(FUNC_CLEAR, KIND_BIND_ALLOW, '0, '0, '0);
        send_item(FUNC_INSERT, KIND_CONNECT_ALLOW, '0, 32'h0A00_0000, 32'hFF00_0000);
        send_item(FUNC_INSERT, KIND_CONNECT_DENY, 16'd443, 32'h0A01_0000, 32'hFFFF_0000);
        send_item(FUNC_CONNECT, KIND_BIND_ALLOW, 16'd443, 32'h0A01_0203, $urandom);
        send_item(FUNC_CONNECT, KIND_BIND_ALLOW, 16'd80, 32'h0A01_0203, $urandom);
        send_item(FUNC_CONNECT, KIND_BIND_ALLOW, 16'd80, 32'h0B00_0001, $urandom);
        send_item(FUNC_INSERT, KIND_CONNECT_ALLOW, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(FUNC_CONNECT, KIND_CONNECT_DENY, 16'hFFFF, 32'hFFFF_FFFF, '0);
        // zero mask: matches every address
        send_item(FUNC_INSERT, KIND_CONNECT_DENY, '0, $urandom, '0);
        send_item(FUNC_CONNECT, KIND_BIND_ALLOW, 16'd80, 32'h0A01_0203, $urandom);
        send_item(FUNC_BIND, KIND_BIND_ALLOW, 16'd80, $urandom, $urandom);
    endtask

    task automatic test_clear_table();
        send_item(FUNC_CLEAR, KIND_CONNECT_DENY, PORT_W'($urandom), $urandom, $urandom);
        send_item(FUNC_CONNECT, KIND_BIND_ALLOW, 16'd80, 32'h0A01_0203, $urandom);
        send_item(FUNC_BIND, KIND_BIND_ALLOW, 16'd80, $urandom, $urandom);
    endtask

    task automatic test_table_full();
        send_item(FUNC_CLEAR, KIND_BIND_ALLOW, '0, '0, '0);
        repeat (TABLE_DEPTH) send_random(FUNC_INSERT);
        send_item(FUNC_INSERT, KIND_BIND_ALLOW, '0, $urandom, $urandom);
        send_item(FUNC_INSERT, KIND_CONNECT_ALLOW, '0, $urandom, '0);
        send_item(FUNC_BIND, KIND_BIND_ALLOW, 16'd80, $urandom, $urandom);
        send_item(FUNC_CONNECT, KIND_BIND_ALLOW, pick_port(), pick_addr(), $urandom);
        send_item(FUNC_CLEAR, KIND_BIND_ALLOW, '0, '0, '0);
        send_item(FUNC_INSERT, KIND_BIND_ALLOW, '0, $urandom, $urandom);
        send_item(FUNC_BIND, KIND_BIND_ALLOW, 16'd1, $urandom, $urandom);
    endtask

    task automatic test_random_traffic();
        int round_len;
        int fill;
        int sel;
        while (random_sent < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0) begin
                fill = $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 4);
                send_random(FUNC_CLEAR);
                repeat (fill) send_random(FUNC_INSERT);
            end else if ($urandom_range(0, 2) == 0) begin
                send_random(FUNC_CLEAR);
            end
            round_len = $urandom_range(10, 40);
            repeat (round_len) begin
                sel = $urandom_range(0, 19);
                if (sel < 7)
                    send_random(FUNC_INSERT);
                else if (sel < 12)
                    send_random(FUNC_BIND);
                else if (sel < 19)
                    send_random(FUNC_CONNECT);
                else
                    send_random(FUNC_CLEAR);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin : main_sequence
        int drain_wait;
        drain_wait = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_bind_rules();
        test_connect_priority();
        test_clear_table();
        test_table_full();
        test_random_traffic();
        start <= 1'b0;
        while (pending_verdicts.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        if (pending_verdicts.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("firewall_rule_matcher_unit verification clean");
        end else begin
            $display("firewall_rule_matcher_unit verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("firewall_rule_matcher_unit verification failed");
        $finish;
    end

endmodule

>>> firewall_rule_matcher_unit.f
src/frm_pkg.sv
src/frm_rule_ram.sv
src/frm_ctrl.sv
src/firewall_rule_matcher_unit.sv
bench/firewall_rule_matcher_unit_tb.sv
